/* src/pol_pkg.sv */
// ----------------------------------------------------------------------------
// pol_pkg
// Shared constants, codes and types of the positional ordered list.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int CAPACITY = 16;
  localparam int CAP_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int LEN_W    = 5;
  localparam int VAL_W    = 32;
  localparam int OP_W     = 4;
  localparam int ST_W     = 2;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd0;
  localparam logic [OP_W-1:0] OP_INS_FRONT = 4'd1;
  localparam logic [OP_W-1:0] OP_INS_END   = 4'd2;
  localparam logic [OP_W-1:0] OP_INS_POS   = 4'd3;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 4'd4;
  localparam logic [OP_W-1:0] OP_DEL_END   = 4'd5;
  localparam logic [OP_W-1:0] OP_DEL_POS   = 4'd6;
  localparam logic [OP_W-1:0] OP_COUNT     = 4'd7;
  localparam logic [OP_W-1:0] OP_READ_ALL  = 4'd8;

  localparam logic [ST_W-1:0] STAT_OK      = 2'd0;
  localparam logic [ST_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [ST_W-1:0] STAT_INVALID = 2'd2;
  localparam logic [ST_W-1:0] STAT_FULL    = 2'd3;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_CLEAR = 3'd1;
  localparam logic [2:0] ACT_INS   = 3'd2;
  localparam logic [2:0] ACT_DEL   = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  typedef struct packed {
    logic [2:0]      act;
    logic [ST_W-1:0] status;
    logic [CAP_W-1:0] idx;
  } plan_t;

endpackage

/* src/positional_ordered_list.sv */
// Results are registered: a result appears in the cycle after the one that
// finishes its item. Clear, count, errors, insert at end and delete at end
// finish in the accept cycle, so such items can be taken every cycle. Other
// inserts and deletes stay busy while they shift, one storage entry moved per
// cycle; read all streams one element per cycle and the receiver cannot stall.
// Reset clears the element count, state, read pointer and valid flag only.
// ----------------------------------------------------------------------------
// positional_ordered_list
// Bounded ordered list of signed words kept in a synchronous memory, edited
// by a shift sequencer and read out one element per cycle.
// ----------------------------------------------------------------------------
module positional_ordered_list (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [pol_pkg::OP_W-1:0]           opcode_i,
  input  logic [pol_pkg::POS_W-1:0]          position_i,
  input  logic signed [pol_pkg::VAL_W-1:0]   value_i,
  output logic                               valid_o,
  output logic signed [pol_pkg::VAL_W-1:0]   value_out_o,
  output logic [pol_pkg::ST_W-1:0]           status_o,
  output logic [pol_pkg::LEN_W-1:0]          length_o,
  output logic                               last_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_DEL  = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [pol_pkg::CNT_W-1:0]  count_q, count_d;
  logic [pol_pkg::CAP_W-1:0]  ptr_q, ptr_d;
  logic [pol_pkg::CAP_W-1:0]  idx_q, idx_d;
  logic [pol_pkg::VAL_W-1:0]  word_q, word_d;

  logic                       valid_q, valid_d;
  logic [pol_pkg::VAL_W-1:0]  value_q, value_d;
  logic [pol_pkg::ST_W-1:0]   status_q, status_d;
  logic [pol_pkg::LEN_W-1:0]  length_q, length_d;
  logic                       last_q, last_d;

  logic                       we;
  logic [pol_pkg::CAP_W-1:0]  waddr;
  logic [pol_pkg::VAL_W-1:0]  wdata;
  logic [pol_pkg::VAL_W-1:0]  rdata;

  pol_pkg::plan_t             plan;
  logic                       accept;
  logic                       ptr_at_end;

  pol_decode u_decode (
    .opcode_i   (opcode_i),
    .position_i (position_i),
    .count_i    (count_q),
    .plan_o     (plan)
  );

  pol_ram #(
    .DEPTH (pol_pkg::CAPACITY),
    .WIDTH (pol_pkg::VAL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ptr_d),
    .rdata_o (rdata)
  );

  assign busy       = (state_q != S_IDLE);
  assign accept     = start && !busy;
  assign ptr_at_end = (pol_pkg::CNT_W'(ptr_q) + pol_pkg::CNT_W'(1) == count_q);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    idx_d    = idx_q;
    word_d   = word_q;
    valid_d  = 1'b0;
    value_d  = '0;
    status_d = pol_pkg::STAT_OK;
    length_d = length_q;
    last_d   = 1'b1;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          valid_d  = 1'b1;
          status_d = plan.status;
          length_d = pol_pkg::LEN_W'(count_q);
          case (plan.act)
            pol_pkg::ACT_CLEAR: begin
              count_d  = '0;
              length_d = '0;
            end
            pol_pkg::ACT_INS: begin
              if (pol_pkg::CNT_W'(plan.idx) == count_q) begin
                // append needs no shifting
                we       = 1'b1;
                waddr    = plan.idx;
                wdata    = $unsigned(value_i);
                count_d  = count_q + pol_pkg::CNT_W'(1);
                length_d = pol_pkg::LEN_W'(count_d);
              end else begin
                valid_d = 1'b0;
                ptr_d   = pol_pkg::CAP_W'(count_q - pol_pkg::CNT_W'(1));
                idx_d   = plan.idx;
                word_d  = $unsigned(value_i);
                state_d = S_INS;
              end
            end
            pol_pkg::ACT_DEL: begin
              if (pol_pkg::CNT_W'(plan.idx) + pol_pkg::CNT_W'(1) == count_q) begin
                count_d  = count_q - pol_pkg::CNT_W'(1);
                length_d = pol_pkg::LEN_W'(count_d);
              end else begin
                valid_d = 1'b0;
                ptr_d   = plan.idx + pol_pkg::CAP_W'(1);
                state_d = S_DEL;
              end
            end
            pol_pkg::ACT_READ: begin
              valid_d = 1'b0;
              ptr_d   = '0;
              state_d = S_READ;
            end
            default: begin
            end
          endcase
        end
      end
      S_INS: begin
        // move entry ptr up by one, walking toward the insert point
        we    = 1'b1;
        waddr = ptr_q + pol_pkg::CAP_W'(1);
        wdata = rdata;
        if (ptr_q == idx_q) begin
          state_d = S_PUT;
        end else begin
          ptr_d = ptr_q - pol_pkg::CAP_W'(1);
        end
      end
      S_PUT: begin
        we       = 1'b1;
        waddr    = idx_q;
        wdata    = word_q;
        count_d  = count_q + pol_pkg::CNT_W'(1);
        valid_d  = 1'b1;
        length_d = pol_pkg::LEN_W'(count_d);
        state_d  = S_IDLE;
      end
      S_DEL: begin
        // move entry ptr down by one, walking toward the end
        we    = 1'b1;
        waddr = ptr_q - pol_pkg::CAP_W'(1);
        wdata = rdata;
        if (ptr_at_end) begin
          count_d  = count_q - pol_pkg::CNT_W'(1);
          valid_d  = 1'b1;
          length_d = pol_pkg::LEN_W'(count_d);
          state_d  = S_IDLE;
        end else begin
          ptr_d = ptr_q + pol_pkg::CAP_W'(1);
        end
      end
      S_READ: begin
        valid_d  = 1'b1;
        value_d  = rdata;
        length_d = pol_pkg::LEN_W'(count_q);
        last_d   = ptr_at_end;
        if (ptr_at_end) begin
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + pol_pkg::CAP_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    word_q   <= word_d;
    value_q  <= value_d;
    status_q <= status_d;
    length_q <= length_d;
    last_q   <= last_d;
  end

  assign valid_o     = valid_q;
  assign value_out_o = $signed(value_q);
  assign status_o    = status_q;
  assign length_o    = length_q;
  assign last_o      = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pol_pkg::CNT_W'(pol_pkg::CAPACITY))
    else $error("element count above capacity");

  a_read_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> valid_o)
    else $error("read all cycle gave no result");

  a_shift_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS || state_q == S_PUT) |-> count_q < pol_pkg::CNT_W'(pol_pkg::CAPACITY))
    else $error("insert shifting on a full list");

  a_put_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUT |=> count_q == $past(count_q) + pol_pkg::CNT_W'(1))
    else $error("insert did not grow the list");

  a_del_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DEL |-> count_q > pol_pkg::CNT_W'(1))
    else $error("delete shifting on a list of one or none");

endmodule

/* src/pol_ram.sv */
// ----------------------------------------------------------------------------
// pol_ram
// Simple dual-port storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pol_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* src/pol_decode.sv */
// ----------------------------------------------------------------------------
// pol_decode
// Turns opcode, position and current length into an action, a status and
// the storage index the action works on.
// ----------------------------------------------------------------------------
module pol_decode (
  input  logic [pol_pkg::OP_W-1:0]  opcode_i,
  input  logic [pol_pkg::POS_W-1:0] position_i,
  input  logic [pol_pkg::CNT_W-1:0] count_i,
  output pol_pkg::plan_t            plan_o
);

  logic [pol_pkg::CMP_W-1:0] cnt_x;
  logic [pol_pkg::CMP_W-1:0] pos_x;
  logic                      full;
  logic                      empty;
  logic                      pos_bad;
  logic [pol_pkg::CAP_W-1:0] idx_end;
  logic [pol_pkg::CAP_W-1:0] idx_last;
  logic [pol_pkg::CAP_W-1:0] idx_pos;

  assign cnt_x    = pol_pkg::CMP_W'(count_i);
  assign pos_x    = pol_pkg::CMP_W'(position_i);
  assign full     = (count_i == pol_pkg::CNT_W'(pol_pkg::CAPACITY));
  assign empty    = (count_i == '0);
  assign pos_bad  = (pos_x == '0) || (pos_x > cnt_x);
  assign idx_end  = pol_pkg::CAP_W'(count_i);
  assign idx_last = pol_pkg::CAP_W'(cnt_x - pol_pkg::CMP_W'(1));
  assign idx_pos  = pol_pkg::CAP_W'(pos_x - pol_pkg::CMP_W'(1));

  always_comb begin
    plan_o.act    = pol_pkg::ACT_NONE;
    plan_o.status = pol_pkg::STAT_OK;
    plan_o.idx    = '0;
    case (opcode_i)
      pol_pkg::OP_CLEAR: begin
        plan_o.act = pol_pkg::ACT_CLEAR;
      end
      pol_pkg::OP_INS_FRONT: begin
        if (full) begin
          plan_o.status = pol_pkg::STAT_FULL;
        end else begin
          plan_o.act = pol_pkg::ACT_INS;
        end
      end
      pol_pkg::OP_INS_END: begin
        if (full) begin
          plan_o.status = pol_pkg::STAT_FULL;
        end else begin
          plan_o.act = pol_pkg::ACT_INS;
          plan_o.idx = idx_end;
        end
      end
      pol_pkg::OP_INS_POS: begin
        // position is checked before fullness
        if (pos_bad) begin
          plan_o.status = pol_pkg::STAT_INVALID;
        end else if (full) begin
          plan_o.status = pol_pkg::STAT_FULL;
        end else begin
          plan_o.act = pol_pkg::ACT_INS;
          plan_o.idx = idx_pos;
        end
      end
      pol_pkg::OP_DEL_FRONT: begin
        if (empty) begin
          plan_o.status = pol_pkg::STAT_EMPTY;
        end else begin
          plan_o.act = pol_pkg::ACT_DEL;
        end
      end
      pol_pkg::OP_DEL_END: begin
        if (empty) begin
          plan_o.status = pol_pkg::STAT_EMPTY;
        end else begin
          plan_o.act = pol_pkg::ACT_DEL;
          plan_o.idx = idx_last;
        end
      end
      pol_pkg::OP_DEL_POS: begin
        // front and end cases come first, so an empty list reports empty at position 0 or 1
        if (pos_x == pol_pkg::CMP_W'(1) || pos_x == cnt_x) begin
          if (empty) begin
            plan_o.status = pol_pkg::STAT_EMPTY;
          end else begin
            plan_o.act = pol_pkg::ACT_DEL;
            plan_o.idx = (pos_x == pol_pkg::CMP_W'(1)) ? '0 : idx_last;
          end
        end else if (pos_bad) begin
          plan_o.status = pol_pkg::STAT_INVALID;
        end else begin
          plan_o.act = pol_pkg::ACT_DEL;
          plan_o.idx = idx_pos;
        end
      end
      pol_pkg::OP_COUNT: begin
        plan_o.act = pol_pkg::ACT_NONE;
      end
      pol_pkg::OP_READ_ALL: begin
        if (empty) begin
          plan_o.status = pol_pkg::STAT_EMPTY;
        end else begin
          plan_o.act = pol_pkg::ACT_READ;
        end
      end
      default: begin
        plan_o.status = pol_pkg::STAT_INVALID;
      end
    endcase
  end

endmodule
